>>> design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// Channel frame receiver package
// Shared constants, register indexes and result kind codes.
// ----------------------------------------------------------------------------
package cfr_pkg;

    // Payload store depth; strings keep at most MAX_LEN-1 bytes.
    localparam int MAX_LEN = 32;
    localparam int ADDR_W  = $clog2(MAX_LEN);

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 7;
    localparam int CFG_W   = 2;

    // Configuration register indexes.
    localparam logic [CFG_W-1:0] REG_STRING_CHANNEL = 2'd0;
    localparam logic [CFG_W-1:0] REG_FLOAT_BASE     = 2'd1;
    localparam logic [CFG_W-1:0] REG_INT16_BASE     = 2'd2;
    localparam logic [CFG_W-1:0] REG_CHANNEL_COUNT  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] RST_STRING_CHANNEL = 8'd10;
    localparam logic [BYTE_W-1:0] RST_FLOAT_BASE     = 8'd11;
    localparam logic [BYTE_W-1:0] RST_INT16_BASE     = 8'd1;
    localparam logic [BYTE_W-1:0] RST_CHANNEL_COUNT  = 8'd9;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_MSG     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACQ_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACQ_ON  = 2'd2;

    // Payload lengths of the fixed-size channels.
    localparam logic [LEN_W-1:0] FLOAT_LEN = 7'd4;
    localparam logic [LEN_W-1:0] INT16_LEN = 7'd2;

endpackage

>>> design/channel_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// Channel frame receiver core
// Assembles channel frames from link bytes in a payload memory and plays
// each finished frame out as a run of result items.
// ----------------------------------------------------------------------------
// Playout: after the last byte of a frame is accepted, each payload byte is read
//   from memory in ST_READ, then loaded into the output registers in ST_LOAD; a
//   frame that gives a single result uses ST_SINGLE. Input takes one byte per cycle
//   while a frame is assembled, is held off during a run; loads wait on a full slot.
// Reset: synchronous, active low; clears control state, acquisition flag and
//   configuration registers. The payload memory is not cleared.
module channel_frame_receiver_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cfr_pkg::CFG_W-1:0]         i_cfg_index,
    input  logic [cfr_pkg::BYTE_W-1:0]        i_cfg_data,
    // input byte channel
    input  logic                              i_rx_valid,
    output logic                              o_rx_ready,
    input  logic [cfr_pkg::BYTE_W-1:0]        i_rx_byte,
    // result channel
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [cfr_pkg::KIND_W-1:0]        o_kind,
    output logic [cfr_pkg::BYTE_W-1:0]        o_channel_id,
    output logic [cfr_pkg::BYTE_W-1:0]        o_data_byte,
    output logic [cfr_pkg::INDEX_W-1:0]       o_byte_index,
    output logic [cfr_pkg::LEN_W-1:0]         o_frame_length,
    output logic                              o_last,
    output logic                              o_acquisition_on
);

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_FIXED,
        PH_STRING
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SINGLE,
        ST_READ,
        ST_LOAD
    } t_state;

    localparam int AW = cfr_pkg::ADDR_W;
    localparam int LW = cfr_pkg::LEN_W;
    localparam int BW = cfr_pkg::BYTE_W;

    localparam logic [LW-1:0] MAX_CNT = LW'(cfr_pkg::MAX_LEN);
    localparam logic [LW-1:0] STR_CNT = LW'(cfr_pkg::MAX_LEN - 1);

    // Configuration registers
    logic [BW-1:0] r_string_channel;
    logic [BW-1:0] r_float_base;
    logic [BW-1:0] r_int16_base;
    logic [BW-1:0] r_channel_count;

    // Control state
    t_state                      r_state, n_state;
    t_phase                      r_phase, n_phase;
    logic [BW-1:0]               r_channel, n_channel;
    logic [LW-1:0]               r_exp_len, n_exp_len;
    logic [LW-1:0]               r_cnt, n_cnt;
    logic [BW-1:0]               r_b0, n_b0;
    logic [BW-1:0]               r_b1, n_b1;
    logic                        r_acq, n_acq;
    logic [cfr_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [AW-1:0]               r_rd_idx, n_rd_idx;
    logic                        r_o_valid, n_o_valid;

    // Output payload registers
    logic [cfr_pkg::KIND_W-1:0]  r_o_kind, n_o_kind;
    logic [BW-1:0]               r_o_channel, n_o_channel;
    logic [BW-1:0]               r_o_data, n_o_data;
    logic [cfr_pkg::INDEX_W-1:0] r_o_index, n_o_index;
    logic [LW-1:0]               r_o_len, n_o_len;
    logic                        r_o_last, n_o_last;
    logic                        r_o_acq, n_o_acq;

    // Payload memory
    logic [BW-1:0] r_mem [cfr_pkg::MAX_LEN];
    logic [BW-1:0] r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_wa;

    logic          rx_acc;
    logic          slot_free;
    logic          in_float;
    logic          in_int16;
    logic [BW:0]   float_end;
    logic [BW:0]   int16_end;
    logic [BW-1:0] eff_b0;
    logic [BW-1:0] eff_b1;
    logic          run_last;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = (r_state == ST_IDLE);
    assign rx_acc      = i_rx_valid && (r_state == ST_IDLE);
    assign slot_free   = !r_o_valid || i_res_ready;

    // Range bounds are formed one bit wider so they do not wrap.
    assign float_end = {1'b0, r_float_base} + {1'b0, r_channel_count};
    assign int16_end = {1'b0, r_int16_base} + {1'b0, r_channel_count};
    assign in_float  = (i_rx_byte >= r_float_base) && ({1'b0, i_rx_byte} < float_end);
    assign in_int16  = (i_rx_byte >= r_int16_base) && ({1'b0, i_rx_byte} < int16_end);

    assign run_last = ((LW'(r_rd_idx) + LW'(1)) == r_cnt);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_channel   = r_channel;
        n_exp_len   = r_exp_len;
        n_cnt       = r_cnt;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_acq       = r_acq;
        n_kind      = r_kind;
        n_rd_idx    = r_rd_idx;
        n_o_valid   = r_o_valid && !i_res_ready;
        n_o_kind    = r_o_kind;
        n_o_channel = r_o_channel;
        n_o_data    = r_o_data;
        n_o_index   = r_o_index;
        n_o_len     = r_o_len;
        n_o_last    = r_o_last;
        n_o_acq     = r_o_acq;
        mem_we      = 1'b0;
        mem_wa      = r_cnt[AW-1:0];
        eff_b0      = r_b0;
        eff_b1      = r_b1;

        case (r_state)
            ST_IDLE: begin
                if (rx_acc) begin
                    case (r_phase)
                        PH_WAIT: begin
                            n_channel = i_rx_byte;
                            n_cnt     = '0;
                            n_b0      = '0;
                            n_b1      = '0;
                            if (i_rx_byte == r_string_channel) begin
                                n_exp_len = '0;
                                if (i_rx_byte == '0) begin
                                    // A zero string channel ends an empty string at once.
                                    n_acq   = 1'b0;
                                    n_kind  = cfr_pkg::KIND_ACQ_OFF;
                                    n_state = ST_SINGLE;
                                end else begin
                                    n_phase = PH_STRING;
                                end
                            end else if (in_float) begin
                                n_exp_len = cfr_pkg::FLOAT_LEN;
                                n_phase   = PH_FIXED;
                            end else if (in_int16) begin
                                n_exp_len = cfr_pkg::INT16_LEN;
                                n_phase   = PH_FIXED;
                            end else begin
                                n_exp_len = '0;
                                n_kind    = cfr_pkg::KIND_MSG;
                                n_state   = ST_SINGLE;
                            end
                        end
                        PH_FIXED: begin
                            if (r_cnt < MAX_CNT) begin
                                mem_we = 1'b1;
                                n_cnt  = r_cnt + LW'(1);
                            end
                            if (n_cnt >= r_exp_len) begin
                                n_phase  = PH_WAIT;
                                n_kind   = cfr_pkg::KIND_MSG;
                                n_rd_idx = '0;
                                n_state  = (n_cnt == '0) ? ST_SINGLE : ST_READ;
                            end
                        end
                        PH_STRING: begin
                            if (r_cnt < STR_CNT) begin
                                mem_we = 1'b1;
                                n_cnt  = r_cnt + LW'(1);
                                if (r_cnt == LW'(0)) begin
                                    n_b0 = i_rx_byte;
                                end
                                if (r_cnt == LW'(1)) begin
                                    n_b1 = i_rx_byte;
                                end
                            end
                            eff_b0 = n_b0;
                            eff_b1 = n_b1;
                            if (i_rx_byte == '0) begin
                                n_phase  = PH_WAIT;
                                n_rd_idx = '0;
                                if (eff_b0 == '0 && eff_b1 == '0) begin
                                    n_acq   = 1'b0;
                                    n_kind  = cfr_pkg::KIND_ACQ_OFF;
                                    n_state = ST_SINGLE;
                                end else if (eff_b0 == BW'(1) && eff_b1 == '0) begin
                                    n_acq   = 1'b1;
                                    n_kind  = cfr_pkg::KIND_ACQ_ON;
                                    n_state = ST_SINGLE;
                                end else begin
                                    n_kind  = cfr_pkg::KIND_MSG;
                                    n_state = (n_cnt == '0) ? ST_SINGLE : ST_READ;
                                end
                            end
                        end
                        default: begin
                            n_phase = PH_WAIT;
                        end
                    endcase
                end
            end
            ST_SINGLE: begin
                // Empty frames and control strings give one result with no data.
                if (slot_free) begin
                    n_o_valid   = 1'b1;
                    n_o_kind    = r_kind;
                    n_o_channel = r_channel;
                    n_o_data    = '0;
                    n_o_index   = '0;
                    n_o_len     = r_cnt;
                    n_o_last    = 1'b1;
                    n_o_acq     = r_acq;
                    n_state     = ST_IDLE;
                end
            end
            ST_READ: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                if (slot_free) begin
                    n_o_valid   = 1'b1;
                    n_o_kind    = cfr_pkg::KIND_MSG;
                    n_o_channel = r_channel;
                    n_o_data    = r_rd_data;
                    n_o_index   = cfr_pkg::INDEX_W'(r_rd_idx);
                    n_o_len     = r_cnt;
                    n_o_last    = run_last;
                    n_o_acq     = r_acq;
                    if (run_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rd_idx = r_rd_idx + AW'(1);
                        n_state  = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_string_channel <= cfr_pkg::RST_STRING_CHANNEL;
            r_float_base     <= cfr_pkg::RST_FLOAT_BASE;
            r_int16_base     <= cfr_pkg::RST_INT16_BASE;
            r_channel_count  <= cfr_pkg::RST_CHANNEL_COUNT;
            r_state          <= ST_IDLE;
            r_phase          <= PH_WAIT;
            r_channel        <= '0;
            r_exp_len        <= '0;
            r_cnt            <= '0;
            r_b0             <= '0;
            r_b1             <= '0;
            r_acq            <= 1'b0;
            r_kind           <= cfr_pkg::KIND_MSG;
            r_rd_idx         <= '0;
            r_o_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    cfr_pkg::REG_STRING_CHANNEL: r_string_channel <= i_cfg_data;
                    cfr_pkg::REG_FLOAT_BASE:     r_float_base     <= i_cfg_data;
                    cfr_pkg::REG_INT16_BASE:     r_int16_base     <= i_cfg_data;
                    cfr_pkg::REG_CHANNEL_COUNT:  r_channel_count  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_channel <= n_channel;
            r_exp_len <= n_exp_len;
            r_cnt     <= n_cnt;
            r_b0      <= n_b0;
            r_b1      <= n_b1;
            r_acq     <= n_acq;
            r_kind    <= n_kind;
            r_rd_idx  <= n_rd_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_kind    <= n_o_kind;
        r_o_channel <= n_o_channel;
        r_o_data    <= n_o_data;
        r_o_index   <= n_o_index;
        r_o_len     <= n_o_len;
        r_o_last    <= n_o_last;
        r_o_acq     <= n_o_acq;
    end

    // Payload memory: one write port, one registered read port. Writes only
    // happen while idle and reads only during a run, so they never collide.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= i_rx_byte;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_res_valid      = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_channel_id     = r_o_channel;
    assign o_data_byte      = r_o_data;
    assign o_byte_index     = r_o_index;
    assign o_frame_length   = r_o_len;
    assign o_last           = r_o_last;
    assign o_acquisition_on = r_o_acq;

endmodule

>>> design/cfr_checker.sv
// ----------------------------------------------------------------------------
// Channel frame receiver port checker
// Watches the result channel of the core and flags inconsistent items.
// ----------------------------------------------------------------------------
module cfr_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_res_valid,
    input logic                        i_res_ready,
    input logic [cfr_pkg::KIND_W-1:0]  o_kind,
    input logic [cfr_pkg::BYTE_W-1:0]  o_data_byte,
    input logic [cfr_pkg::INDEX_W-1:0] o_byte_index,
    input logic [cfr_pkg::LEN_W-1:0]   o_frame_length,
    input logic                        o_last,
    input logic                        o_acquisition_on
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid)
        else $error("result item dropped while stalled");

    // Control results are single items with no data.
    a_ctrl_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind != cfr_pkg::KIND_MSG |->
            o_last && o_data_byte == '0 && o_byte_index == '0)
        else $error("control item is not a single empty item");

    // The acquisition flag follows the control command that was taken.
    a_ctrl_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_kind == cfr_pkg::KIND_ACQ_ON || o_kind == cfr_pkg::KIND_ACQ_OFF) |->
            o_acquisition_on == (o_kind == cfr_pkg::KIND_ACQ_ON))
        else $error("acquisition flag does not match control item");

    // The last mark sits on the final byte of the run, or on an empty frame.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_kind == cfr_pkg::KIND_MSG |->
            o_last == (o_frame_length == '0 ||
                       (cfr_pkg::LEN_W'(o_byte_index) + cfr_pkg::LEN_W'(1)) == o_frame_length))
        else $error("last mark out of place");

    // Within a run, the next item follows the previous index by one.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_ready && !o_last ##1 o_res_valid |->
            o_byte_index == $past(o_byte_index) + cfr_pkg::INDEX_W'(1))
        else $error("byte index skipped within a run");

endmodule

bind channel_frame_receiver_core cfr_checker u_cfr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_res_valid      (o_res_valid),
    .i_res_ready      (i_res_ready),
    .o_kind           (o_kind),
    .o_data_byte      (o_data_byte),
    .o_byte_index     (o_byte_index),
    .o_frame_length   (o_frame_length),
    .o_last           (o_last),
    .o_acquisition_on (o_acquisition_on)
);
